### design/line_substring_filter_core_defines.svh
// ----------------------------------------------------------------------------
// line_substring_filter_core_defines.svh
// Assertion macros shared by the checking code of the line substring filter.
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_CORE_DEFINES_SVH
`define LINE_SUBSTRING_FILTER_CORE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define LSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LSF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Types and constants shared by the line substring filter modules.
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2,
		CFG_INVERT_SELECT  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [63:0] pattern_low_bytes;
		logic [63:0] pattern_high_bytes;
		logic [4:0]  pattern_length;
		logic        invert_select;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
		logic       is_newline;
	} text_entry_t;

endpackage

### design/lsf_channels.sv
// ----------------------------------------------------------------------------
// lsf_channels
// Valid/ready channels for text bytes and for chunk records.
// ----------------------------------------------------------------------------
interface lsf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lsf_rec_if;
	logic        valid;
	logic        ready;
	logic [31:0] line_number;
	logic        selected;
	logic [12:0] chunk_length;
	logic        ended_by_newline;

	modport source (output valid, output line_number, output selected,
		output chunk_length, output ended_by_newline, input ready);
	modport sink (input valid, input line_number, input selected,
		input chunk_length, input ended_by_newline, output ready);
endinterface

### design/lsf_front.sv
// ----------------------------------------------------------------------------
// lsf_front
// Accepts text transactions and classifies each into a queue entry.
// ----------------------------------------------------------------------------
module lsf_front
	import lsf_pkg::*;
(
	lsf_text_if.sink    text_ch,
	output logic        push_valid,
	input  logic        push_ready,
	output text_entry_t push_entry
);

	always_comb begin
		text_ch.ready            = push_ready;
		push_valid               = text_ch.valid;
		push_entry.data_byte     = text_ch.data_byte;
		push_entry.end_of_stream = text_ch.end_of_stream;
		push_entry.is_newline    = !text_ch.end_of_stream && (text_ch.data_byte == NEWLINE_CHAR);
	end

endmodule

### design/lsf_fifo.sv
// ----------------------------------------------------------------------------
// lsf_fifo
// Short queue of classified text entries between the front and back parts.
// ----------------------------------------------------------------------------
module lsf_fifo
	import lsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  text_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output text_entry_t pop_entry
);

	text_entry_t            store_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	always_comb begin
		push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
		pop_valid  = (count_q != '0);
		pop_entry  = store_q[rd_ptr_q];
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/lsf_back.sv
// ----------------------------------------------------------------------------
// lsf_back
// Window compare, chunk and line counting, and the record output register.
// ----------------------------------------------------------------------------
module lsf_back
	import lsf_pkg::*;
#(
	parameter int LINE_CHUNK_MAX = 8192,
	parameter int PATTERN_MAX    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  text_entry_t pop_entry,
	lsf_rec_if.source   rec_ch
);

	localparam int CW = $clog2(LINE_CHUNK_MAX);
	localparam logic [CW-1:0] LAST_COUNT = CW'(LINE_CHUNK_MAX - 1);
	localparam logic [4:0]    PM_LEN     = 5'(PATTERN_MAX);

	logic [PATTERN_MAX-1:0][7:0] window_q;
	logic [PATTERN_MAX-1:0][7:0] window_new;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_new;
	logic                        match_q;
	logic                        match_new;
	logic [31:0]                 line_q;
	logic [31:0]                 line_next;
	logic [127:0]                pattern;
	logic [4:0]                  act_len;
	logic [PATTERN_MAX:1]        full_match;
	logic                        sel_match;
	logic                        advance;
	logic                        do_pop;
	logic                        emit;
	logic                        emit_hit;
	logic                        emit_by_nl;
	logic [CW-1:0]               emit_len;

	logic        rec_valid_q;
	logic [31:0] rec_line_q;
	logic        rec_sel_q;
	logic [12:0] rec_len_q;
	logic        rec_nl_q;

	always_comb begin
		pattern = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
		act_len = (cfg.pattern_length > PM_LEN) ? PM_LEN : cfg.pattern_length;

		window_new[0] = pop_entry.data_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			window_new[k] = window_q[k-1];
		end
		count_new = count_q + 1'b1;

		for (int n = 1; n <= PATTERN_MAX; n++) begin
			full_match[n] = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (window_new[n-1-i] != pattern[8*i +: 8]) begin
					full_match[n] = 1'b0;
				end
			end
		end
		sel_match = 1'b0;
		for (int n = 1; n <= PATTERN_MAX; n++) begin
			if (act_len == 5'(n)) begin
				sel_match = full_match[n];
			end
		end
		match_new = match_q || (act_len == '0) ||
			((32'(count_new) >= 32'(act_len)) && sel_match);

		advance = !rec_valid_q || rec_ch.ready;
		pop_ready = advance;
		do_pop = pop_valid && advance;

		if (pop_entry.end_of_stream) begin
			emit       = (count_q != '0);
			emit_hit   = match_q || (act_len == '0);
			emit_by_nl = 1'b0;
			emit_len   = count_q;
		end else begin
			emit       = pop_entry.is_newline || (count_new == LAST_COUNT);
			emit_hit   = match_new;
			emit_by_nl = pop_entry.is_newline;
			emit_len   = count_new;
		end
		line_next = line_q + 1'b1;

		rec_ch.valid            = rec_valid_q;
		rec_ch.line_number      = rec_line_q;
		rec_ch.selected         = rec_sel_q;
		rec_ch.chunk_length     = rec_len_q;
		rec_ch.ended_by_newline = rec_nl_q;
	end

	always_ff @(posedge clk) begin
		if (do_pop && !pop_entry.end_of_stream) begin
			window_q <= window_new;
		end
		if (do_pop && emit) begin
			rec_line_q <= line_next;
			rec_sel_q  <= emit_hit ^ cfg.invert_select;
			rec_len_q  <= 13'(emit_len);
			rec_nl_q   <= emit_by_nl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			match_q     <= 1'b0;
			line_q      <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rec_valid_q <= do_pop && emit;
			end
			if (do_pop) begin
				if (pop_entry.end_of_stream) begin
					count_q <= '0;
					match_q <= 1'b0;
					line_q  <= '0;
				end else if (emit) begin
					count_q <= '0;
					match_q <= 1'b0;
					line_q  <= line_next;
				end else begin
					count_q <= count_new;
					match_q <= match_new;
				end
			end
		end
	end

endmodule

### design/line_substring_filter_core.sv
// ----------------------------------------------------------------------------
// line_substring_filter_core
// Splits a text byte stream into line chunks and flags chunks holding a
// configured fixed pattern, or with invert set the chunks without it.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// text_ch   in         data_byte[7:0], end_of_stream
// rec_ch    out        line_number[31:0], selected, chunk_length[12:0],
//                      ended_by_newline
//
// One text transaction is taken every cycle while the queue has room; the
// window compare and the counters in the back part retire one queued byte per
// cycle while the record register is empty or being taken.
// The four-entry queue and the record register let either side stall alone.
// Reset clears counters, queue and record valid; no clearing pass follows.
// ----------------------------------------------------------------------------
module line_substring_filter_core
	import lsf_pkg::*;
#(
	parameter int LINE_CHUNK_MAX = 8192,
	parameter int PATTERN_MAX    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lsf_text_if.sink               text_ch,
	lsf_rec_if.source              rec_ch
);

	cfg_t        cfg_q;
	logic        push_valid;
	logic        push_ready;
	text_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	text_entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW:    cfg_q.pattern_low_bytes  <= cfg_data;
				CFG_PATTERN_HIGH:   cfg_q.pattern_high_bytes <= cfg_data;
				CFG_PATTERN_LENGTH: cfg_q.pattern_length     <= cfg_data[4:0];
				CFG_INVERT_SELECT:  cfg_q.invert_select      <= cfg_data[0];
				default:            cfg_q                    <= cfg_q;
			endcase
		end
	end

	lsf_front u_front (
		.text_ch    (text_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	lsf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	lsf_back #(
		.LINE_CHUNK_MAX (LINE_CHUNK_MAX),
		.PATTERN_MAX    (PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.rec_ch    (rec_ch)
	);

endmodule

### design/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks on the line substring filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "line_substring_filter_core_defines.svh"

module lsf_checker #(
	parameter int LINE_CHUNK_MAX = 8192
) (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_ready,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [31:0] rec_line_number,
	input logic        rec_selected,
	input logic [12:0] rec_chunk_length,
	input logic        rec_ended_by_newline
);

	logic        any_text_q;
	logic [46:0] rec_payload;

	assign rec_payload = {rec_line_number, rec_selected, rec_chunk_length, rec_ended_by_newline};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_text_q <= 1'b0;
		end else if (text_valid && text_ready) begin
			any_text_q <= 1'b1;
		end
	end

	// A stalled record transaction keeps its contents.
	`LSF_ASSERT(a_rec_hold, rec_valid && !rec_ready |=> rec_valid && $stable(rec_payload), "record changed while stalled")
	`LSF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rec_valid, "record offered during reset")
	`LSF_ASSERT(a_len_nonzero, rec_valid && LINE_CHUNK_MAX <= 8192 |-> rec_chunk_length != '0, "empty chunk reported")
	`LSF_ASSERT(a_needs_text, rec_valid |-> any_text_q, "record without any text transaction")

endmodule

bind line_substring_filter_core lsf_checker #(
	.LINE_CHUNK_MAX (LINE_CHUNK_MAX)
) u_lsf_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.text_valid           (text_ch.valid),
	.text_ready           (text_ch.ready),
	.rec_valid            (rec_ch.valid),
	.rec_ready            (rec_ch.ready),
	.rec_line_number      (rec_ch.line_number),
	.rec_selected         (rec_ch.selected),
	.rec_chunk_length     (rec_ch.chunk_length),
	.rec_ended_by_newline (rec_ch.ended_by_newline)
);

### verif/line_substring_filter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line substring filter testbench
// Feeds text bytes and end-of-stream marks into the line substring filter and
// checks every chunk record against a predictor kept in a small scoreboard.
// A short directed run covers empty and flushed chunks, zero and newline
// bytes in the pattern, an over-long pattern length and the all-ones
// settings. Phases of random lines under random settings follow, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
	import lsf_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 9;
	localparam int CHUNK_LIMIT = 8192;
	localparam int PATTERN_LIMIT = 16;
	localparam int WINDOW_DEPTH = 16;
	localparam int RANDOM_ITEMS = 700;
	localparam int RANDOM_PHASES = 7;
	localparam int MAX_IDLE = 18;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS = 30;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] line_number;
		logic        selected;
		logic [12:0] chunk_length;
		logic        ended_by_newline;
	} chunk_rec_t;

	class chunk_scoreboard;
		logic [63:0] pat_low;
		logic [63:0] pat_high;
		logic [4:0]  pat_len;
		logic        invert;
		logic [7:0]  window [WINDOW_DEPTH];
		int unsigned chunk_bytes;
		bit          hit_seen;
		logic [31:0] line_count;
		chunk_rec_t  pending [$];
		int unsigned mismatches;
		int unsigned records;
		int unsigned selected_records;

		function new();
			pat_low = '0;
			pat_high = '0;
			pat_len = '0;
			invert = 1'b0;
			clear_chunk();
			line_count = '0;
			mismatches = 0;
			records = 0;
			selected_records = 0;
		endfunction

		function void set_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
				logic inv);
			pat_low = lo;
			pat_high = hi;
			pat_len = len;
			invert = inv;
		endfunction

		function int unsigned active_len();
			return (pat_len > PATTERN_LIMIT) ? PATTERN_LIMIT : pat_len;
		endfunction

		function logic [7:0] pattern_byte(int unsigned idx);
			logic [127:0] both;
			both = {pat_high, pat_low};
			return both[idx*8 +: 8];
		endfunction

		function void clear_chunk();
			foreach (window[i])
				window[i] = '0;
			chunk_bytes = 0;
			hit_seen = 1'b0;
		endfunction

		function void close_chunk(bit by_newline);
			chunk_rec_t rec;
			line_count = line_count + 1;
			rec.line_number = line_count;
			rec.selected = (hit_seen || active_len() == 0) ^ invert;
			rec.chunk_length = chunk_bytes[12:0];
			rec.ended_by_newline = by_newline;
			pending.push_back(rec);
			clear_chunk();
		endfunction

		function void note_text(logic [7:0] b, logic eos);
			int unsigned n;
			bit same;
			if (eos) begin
				if (chunk_bytes > 0)
					close_chunk(1'b0);
				clear_chunk();
				line_count = '0;
				return;
			end
			for (int i = WINDOW_DEPTH - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			chunk_bytes++;
			n = active_len();
			same = (chunk_bytes >= n);
			for (int i = 0; i < n; i++)
				if (window[n-1-i] != pattern_byte(i))
					same = 1'b0;
			if (same)
				hit_seen = 1'b1;
			if (b == NEWLINE_CHAR)
				close_chunk(1'b1);
			else if (chunk_bytes >= CHUNK_LIMIT - 1)
				close_chunk(1'b0);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_record(chunk_rec_t got);
			chunk_rec_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("record line %0d length %0d with none expected",
					got.line_number, got.chunk_length));
				return;
			end
			want = pending.pop_front();
			records++;
			if (want.selected)
				selected_records++;
			if (got.line_number !== want.line_number)
				report_mismatch($sformatf("line_number %0d, expected %0d",
					got.line_number, want.line_number));
			if (got.selected !== want.selected)
				report_mismatch($sformatf("selected %b, expected %b on line %0d",
					got.selected, want.selected, want.line_number));
			if (got.chunk_length !== want.chunk_length)
				report_mismatch($sformatf("chunk_length %0d, expected %0d on line %0d",
					got.chunk_length, want.chunk_length, want.line_number));
			if (got.ended_by_newline !== want.ended_by_newline)
				report_mismatch($sformatf("ended_by_newline %b, expected %b on line %0d",
					got.ended_by_newline, want.ended_by_newline, want.line_number));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	lsf_text_if text_ch();
	lsf_rec_if  rec_ch();

	chunk_scoreboard sb;
	bit              src_idle;
	bit              snk_idle;
	int unsigned     text_items;
	int unsigned     settings;
	longint          cycles;

	line_substring_filter_core #(
		.LINE_CHUNK_MAX(CHUNK_LIMIT),
		.PATTERN_MAX   (PATTERN_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.text_ch  (text_ch),
		.rec_ch   (rec_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [7:0] text_byte();
		int unsigned n;
		int unsigned r;
		n = sb.active_len();
		r = $urandom_range(0, 9);
		if (r < 4)
			return (n != 0) ? sb.pattern_byte($urandom_range(0, n - 1)) : 8'h61;
		if (r < 6)
			return 8'(8'h61 + $urandom_range(0, 2));
		if (r < 7)
			return 8'h00;
		if (r < 8)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic send_text(logic [7:0] b, logic eos);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		text_ch.end_of_stream <= eos;
		do @(posedge clk); while (!text_ch.ready);
		sb.note_text(b, eos);
		text_items++;
	endtask

	task automatic send_line(int unsigned len, bit with_pattern, bit terminate);
		int unsigned at;
		int unsigned n;
		int unsigned k;
		n = sb.active_len();
		at = with_pattern ? $urandom_range(0, len) : len + 1;
		k = ($urandom_range(0, 3) == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
		for (int i = 0; i <= len; i++) begin
			if (i == at)
				for (int j = 0; j < k; j++)
					send_text(sb.pattern_byte(j), 1'b0);
			if (i < len)
				send_text(text_byte(), 1'b0);
		end
		if (terminate)
			send_text(NEWLINE_CHAR, 1'b0);
	endtask

	task automatic write_settings(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
			logic inv);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			junk = '0;
		cfg_write <= 1'b1;
		cfg_index <= CFG_PATTERN_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_data <= {junk[63:5], len};
		@(posedge clk);
		cfg_index <= CFG_INVERT_SELECT;
		cfg_data <= {junk[63:1], inv};
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_config(lo, hi, len, inv);
		settings++;
	endtask

	task automatic settle();
		text_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		chunk_rec_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = snk_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall != 0) begin
				rec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rec_ch.ready <= 1'b1;
			do @(posedge clk); while (!rec_ch.valid);
			got.line_number = rec_ch.line_number;
			got.selected = rec_ch.selected;
			got.chunk_length = rec_ch.chunk_length;
			got.ended_by_newline = rec_ch.ended_by_newline;
			sb.check_record(got);
		end
	end

	initial begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		logic [7:0]  b;
		int unsigned r;
		int unsigned start;
		sb = new();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		text_items = 0;
		settings = 0;
		cycles = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_PATTERN_LOW;
		cfg_data = '0;
		text_ch.valid = 1'b0;
		text_ch.data_byte = '0;
		text_ch.end_of_stream = 1'b0;
		rec_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty pattern, so every chunk is selected.
		send_text(NEWLINE_CHAR, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		send_text(8'hA5, 1'b1);
		send_text(8'h5A, 1'b1);
		settle();

		// A zero byte followed by a newline as the pattern.
		write_settings({48'h0, NEWLINE_CHAR, 8'h00}, 64'h0, 5'd2, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(NEWLINE_CHAR, 1'b0);
		send_text(8'h78, 1'b0);
		send_text(NEWLINE_CHAR, 1'b0);
		settle();

		// The pattern split by an end of stream must not match.
		write_settings(64'h6261, 64'h0, 5'd2, 1'b0);
		send_text(8'h61, 1'b0);
		send_text(8'h00, 1'b1);
		send_text(8'h62, 1'b0);
		send_text(NEWLINE_CHAR, 1'b0);
		settle();

		// Length above the window acts as sixteen bytes, result inverted.
		write_settings('1, '1, 5'd31, 1'b1);
		repeat (PATTERN_LIMIT) send_text(8'hFF, 1'b0);
		send_text(NEWLINE_CHAR, 1'b0);
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				len = 5'd0;
			else if (r < 7)
				len = 5'($urandom_range(1, 4));
			else if (r == 7)
				len = 5'd16;
			else if (r == 8)
				len = 5'($urandom_range(5, 15));
			else
				len = 5'($urandom_range(17, 31));
			for (int i = 0; i < 16; i++) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					b = 8'(8'h61 + $urandom_range(0, 2));
				else if (r == 6)
					b = 8'h00;
				else if (r == 7)
					b = NEWLINE_CHAR;
				else
					b = 8'($urandom_range(0, 255));
				if (i < 8)
					lo[i*8 +: 8] = b;
				else
					hi[(i-8)*8 +: 8] = b;
			end
			// Any chunk left open from the last phase carries on under the new settings.
			write_settings(lo, hi, len, 1'($urandom_range(0, 1)));
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;
			start = text_items;
			while (text_items - start < RANDOM_ITEMS / RANDOM_PHASES) begin
				if ($urandom_range(0, 24) == 0)
					src_idle = !src_idle;
				if ($urandom_range(0, 24) == 0)
					snk_idle = !snk_idle;
				r = $urandom_range(0, 99);
				if (r < 65) begin
					send_line($urandom_range(0, 20), 1'($urandom_range(0, 1)), 1'b1);
				end else if (r < 75) begin
					send_line($urandom_range(0, 12), 1'($urandom_range(0, 1)), 1'b0);
					send_text(8'($urandom_range(0, 255)), 1'b1);
				end else if (r < 80) begin
					send_text(8'($urandom_range(0, 255)), 1'b1);
				end else if (r < 85) begin
					send_line($urandom_range(20, 60), 1'($urandom_range(0, 1)), 1'b1);
				end else begin
					repeat ($urandom_range(1, 8))
						send_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				end
			end
			if ($urandom_range(0, 1))
				send_line($urandom_range(1, 6), 1'($urandom_range(0, 1)), 1'b0);
			settle();
		end

		$display("%0d text transactions under %0d settings; %0d chunk records checked, %0d selected",
			text_items, settings, sb.records, sb.selected_records);
		$display("covered empty and flushed chunks and over-long pattern lengths; %0d mismatches seen",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
